// ----- rtl/core/blpe_pkg.sv -----
// blpe_pkg: shared types, codes and blink pattern rom for the led blink pattern engine
// no dependencies; imported by every module of the block
`default_nettype none

package blpe_pkg;

    localparam int NUM_LEDS     = 8;
    localparam int LED_SLOTS    = 8;
    localparam int LED_W        = 3;
    localparam int PATTERN_BITS = 160;
    localparam int NUM_PATTERNS = 12;
    localparam int ROM_BITS     = 160;
    localparam int ROM_ROWS     = 16;
    localparam int PHASE_W      = 8;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 4;
    localparam int PAT_W    = 4;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ON     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OFF    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 2'd2;

    // pattern codes with special meaning
    localparam logic [PAT_W-1:0] PAT_ALT = 4'd0;
    localparam logic [PAT_W-1:0] PAT_OFF = 4'd1;
    localparam logic [PAT_W-1:0] PAT_ON  = 4'd2;

    // leftmost hex digit holds the earliest samples
    localparam logic [ROM_BITS-1:0] BLINK_ROM [ROM_ROWS] = '{
        160'h0,
        160'h0,
        160'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF,
        160'hFFFFF00000FFFFF00000FFFFF00000FFFFF00000,
        160'hFF00FF00FF00FF00FF00FF00FF00FF00FF00FF00,
        160'h3333333333333333333333333333333333333333,
        160'h5555555555555555555555555555555555555555,
        160'h0101010101010101010101010101010101010101,
        160'h1111111111111111111111111111111111111111,
        160'h5500550055005500550055005500550055005500,
        160'h5500550055005500550055005500550055005500,
        160'h0CFF0CFF0CFF0CFF0CFF0CFF0CFF0CFF0CFF0CFF,
        160'h0,
        160'h0,
        160'h0,
        160'h0
    };

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] led_index;
        logic [PAT_W-1:0] pattern_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [LED_SLOTS-1:0] led_levels;
        logic [LED_SLOTS-1:0] led_driven;
    } t_rsp;

    function automatic logic rom_bit(input logic [PAT_W-1:0] pat,
                                     input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] pos;
        pos = PHASE_W'(ROM_BITS - 1) - ph;
        if ({1'b0, ph} >= (PHASE_W+1)'(ROM_BITS)) begin
            return 1'b0;
        end
        return BLINK_ROM[pat][pos];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/led_blink_pattern_engine_top.sv -----
// led_blink_pattern_engine_top: top level of the led blink pattern engine
// depends on blpe_pkg, blpe_in_stage, blpe_engine, blpe_out_stage
//
// usage:
//   requests enter on the slave stream (i_s_*), one word per request:
//   tick, set pattern, on, off or toggle. each request returns exactly one
//   word on the master stream (o_m_*) with status, the held led levels and
//   the drive mask, taken after the request is applied.
//   an accepted word goes from the input register through the engine into
//   the output register. throughput: one request per cycle while i_m_tready
//   is high; the input register, the engine's state update and the output
//   register form a two-stage pipeline with no stall of its own.
//   when the receiver holds i_m_tready low, the result word holds, one more
//   request waits in the input register, and then o_s_tready drops.
//   reset (i_rst_n low, synchronous) empties both registers, sets the phase
//   to zero, all leds to alt-function and all held levels low.
`default_nettype none

module led_blink_pattern_engine_top
    import blpe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // led_index[3:0], pattern_index[7:4]
    input  wire logic [REQ_W-1:0]     i_s_tuser,  // req_type[2:0]
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata   // status[1:0], led_levels[9:2],
                                                  // led_driven[17:10], zero[23:18]
);

    t_req in_req;
    t_req stg_req;
    t_rsp eng_rsp;
    t_rsp out_rsp;
    logic stg_valid;
    logic adv;

    assign in_req.req_type      = i_s_tuser;
    assign in_req.led_index     = i_s_tdata[IDX_W-1:0];
    assign in_req.pattern_index = i_s_tdata[IDX_W+PAT_W-1:IDX_W];

    blpe_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_req   (in_req),
        .o_ready (o_s_tready),
        .i_adv   (adv),
        .o_valid (stg_valid),
        .o_req   (stg_req)
    );

    blpe_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (stg_valid && adv),
        .i_req   (stg_req),
        .o_rsp   (eng_rsp)
    );

    blpe_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid),
        .i_rsp   (eng_rsp),
        .o_adv   (adv),
        .o_valid (o_m_tvalid),
        .o_rsp   (out_rsp),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {
        (M_TDATA_W - STATUS_W - 2*LED_SLOTS)'(0),
        out_rsp.led_driven,
        out_rsp.led_levels,
        out_rsp.status
    };

endmodule

`default_nettype wire

// ----- rtl/core/blpe_in_stage.sv -----
// blpe_in_stage: input register of the request stream
// depends on blpe_pkg
`default_nettype none

module blpe_in_stage
    import blpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_req i_req,
    output logic      o_ready,
    input  wire logic i_adv,
    output logic      o_valid,
    output t_req      o_req
);

    logic r_valid;
    t_req r_req;

    // slot frees when the engine consumes it this cycle
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

// ----- rtl/core/blpe_engine.sv -----
// blpe_engine: phase counter, per-led pattern select and held levels, request decode
// depends on blpe_pkg
`default_nettype none

module blpe_engine
    import blpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    logic [PHASE_W-1:0]                r_phase, n_phase;
    logic [LED_SLOTS-1:0][PAT_W-1:0]   r_sel, n_sel;
    logic [LED_SLOTS-1:0]              r_hold, n_hold;
    logic [PHASE_W:0]                  phase_inc;
    logic [LED_W-1:0]                  led;
    logic                              led_bad;
    logic                              pat_bad;
    logic [STATUS_W-1:0]               status;

    assign phase_inc = {1'b0, r_phase} + (PHASE_W+1)'(1);
    assign led       = i_req.led_index[LED_W-1:0];
    assign led_bad   = {1'b0, i_req.led_index} >= (IDX_W+1)'(NUM_LEDS);
    assign pat_bad   = {1'b0, i_req.pattern_index} >= (PAT_W+1)'(NUM_PATTERNS);

    always_comb begin
        n_phase = r_phase;
        n_sel   = r_sel;
        n_hold  = r_hold;
        status  = ST_OK;
        unique case (i_req.req_type) inside
            REQ_TICK: begin
                if (phase_inc >= (PHASE_W+1)'(PATTERN_BITS)) begin
                    n_phase = '0;
                end else begin
                    n_phase = phase_inc[PHASE_W-1:0];
                end
                // alt-function leds keep their last level
                for (int i = 0; i < LED_SLOTS; i++) begin
                    if (i < NUM_LEDS && r_sel[i] != PAT_ALT) begin
                        n_hold[i] = rom_bit(r_sel[i], n_phase);
                    end
                end
            end
            REQ_SET, REQ_ON, REQ_OFF, REQ_TOGGLE: begin
                if (led_bad) begin
                    status = ST_BAD_ARG;
                end else if (i_req.req_type == REQ_SET) begin
                    if (pat_bad) begin
                        status = ST_BAD_ARG;
                    end else begin
                        n_sel[led] = i_req.pattern_index;
                    end
                end else if (r_sel[led] == PAT_ALT) begin
                    status = ST_BAD_STATE;
                end else if (i_req.req_type == REQ_ON) begin
                    n_sel[led] = PAT_ON;
                end else if (i_req.req_type == REQ_OFF) begin
                    n_sel[led] = PAT_OFF;
                end else begin
                    n_sel[led] = (r_sel[led] == PAT_ON) ? PAT_OFF : PAT_ON;
                end
            end
            default: begin
                status = ST_BAD_ARG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_sel   <= '0;
            r_hold  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_sel   <= n_sel;
            r_hold  <= n_hold;
        end
    end

    // response reflects the state after the request
    always_comb begin
        o_rsp.status     = status;
        o_rsp.led_levels = '0;
        o_rsp.led_driven = '0;
        for (int i = 0; i < LED_SLOTS; i++) begin
            if (i < NUM_LEDS) begin
                o_rsp.led_levels[i] = n_hold[i];
                o_rsp.led_driven[i] = (n_sel[i] != PAT_ALT);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/blpe_out_stage.sv -----
// blpe_out_stage: result register of the response stream
// depends on blpe_pkg
`default_nettype none

module blpe_out_stage
    import blpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_rsp i_rsp,
    output logic      o_adv,
    output logic      o_valid,
    output t_rsp      o_rsp,
    input  wire logic i_ready
);

    logic r_valid;
    t_rsp r_rsp;

    // load when empty or when the held word is being taken
    assign o_adv = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ----- rtl/core/blpe_checker.sv -----
// blpe_checker: port-level checks for the led blink pattern engine, bound to the top level
// depends on blpe_pkg and led_blink_pattern_engine_top
`default_nettype none

module blpe_checker
    import blpe_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[STATUS_W-1:0] == ST_OK ||
                        o_m_tdata[STATUS_W-1:0] == ST_BAD_ARG ||
                        o_m_tdata[STATUS_W-1:0] == ST_BAD_STATE))
        else $error("unknown status code");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[M_TDATA_W-1:STATUS_W+2*LED_SLOTS] == '0)
        else $error("padding bits set in result word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("pipeline not empty after reset");

endmodule

bind led_blink_pattern_engine_top blpe_checker u_blpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
